// File: design/pbts_pkg.sv
package pbts_pkg;
    localparam int TASKS_DEF = 16;
    localparam int PRIO_DEF  = 32;

    localparam logic [3:0] CMD_CREATE  = 4'd0;
    localparam logic [3:0] CMD_DELETE  = 4'd1;
    localparam logic [3:0] CMD_SETPRIO = 4'd2;
    localparam logic [3:0] CMD_WAIT    = 4'd3;
    localparam logic [3:0] CMD_WAKEUP  = 4'd4;
    localparam logic [3:0] CMD_SUSPEND = 4'd5;
    localparam logic [3:0] CMD_RESUME  = 4'd6;
    localparam logic [3:0] CMD_SWITCH  = 4'd7;
    localparam logic [3:0] CMD_LOCK    = 4'd8;
    localparam logic [3:0] CMD_UNLOCK  = 4'd9;
    localparam logic [3:0] CMD_TICK    = 4'd10;
    localparam logic [3:0] CMD_JOIN    = 4'd11;

    localparam logic [1:0] ST_DEAD    = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_BLOCKED = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_ILLEGAL = 2'd2;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [3:0]  target_task;
        logic [5:0]  priority_req;
        logic [14:0] event_tag;
        logic [7:0]  wake_limit;
    } t_cmd_word;
endpackage

// File: design/pbts_queue.sv
module pbts_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  pbts_pkg::t_cmd_word i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output pbts_pkg::t_cmd_word o_word
);
    import pbts_pkg::*;

    t_cmd_word r_mem [2];
    logic      r_wp, r_rp;
    logic [1:0] r_cnt;
    logic      push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_word;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !push) else $error("push into full queue");
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !push |=> r_cnt == $past(r_cnt) - 2'd1) else $error("pop count");
endmodule

// File: design/pbts_engine.sv
module pbts_engine #(
    parameter int TASKS       = pbts_pkg::TASKS_DEF,
    parameter int PRIO_LEVELS = pbts_pkg::PRIO_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  pbts_pkg::t_cmd_word i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [3:0]          o_result_task,
    output logic [1:0]          o_status,
    output logic [3:0]          o_running_task,
    output logic                o_running_valid,
    output logic                o_switch_request,
    output logic [7:0]          o_lock_level,
    output logic [4:0]          o_woken_count
);
    import pbts_pkg::*;

    localparam int TW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int CW = $clog2(TASKS + 1);
    localparam logic [4:0] PMAX = 5'(PRIO_LEVELS - 1);

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SCAN, S_WAKE, S_DONE} t_state;

    t_state      r_state;
    t_cmd_word   r_cmd;
    logic [1:0]  r_tst   [TASKS];
    logic [4:0]  r_prio  [TASKS];
    logic [15:0] r_tag   [TASKS];
    logic [7:0]  r_stamp [TASKS];
    logic [7:0]  r_order;
    logic [TW-1:0] r_fifo [TASKS];
    logic [TW-1:0] r_fhead;
    logic [CW-1:0] r_fcount;
    logic        r_cur_v;
    logic [TW-1:0] r_cur;
    logic [7:0]  r_lock;
    logic [15:0] r_wtag;
    logic [7:0]  r_wlimit;
    logic [4:0]  r_woken;
    logic        r_sched;
    // scan state
    logic [CW-1:0] r_idx;
    logic        r_best_v;
    logic [TW-1:0] r_best;
    logic [4:0]  r_bprio;
    logic [7:0]  r_bstamp;
    // output word
    logic [3:0]  r_o_res;
    logic [1:0]  r_o_st;
    logic [4:0]  r_o_wk;
    logic        r_o_sw;
    logic        r_ovalid;

    logic [TW-1:0] tix, sidx;
    logic [4:0]  sat_p;
    logic        tbad;

    assign tix   = r_cmd.target_task[TW-1:0];
    assign tbad  = 32'(r_cmd.target_task) >= TASKS;
    assign sat_p = (r_cmd.priority_req > 6'(PMAX)) ? PMAX : r_cmd.priority_req[4:0];
    assign sidx  = r_idx[TW-1:0];

    assign o_ready          = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid          = r_ovalid;
    assign o_result_task    = r_o_res;
    assign o_status         = r_o_st;
    assign o_running_task   = r_cur_v ? 4'(r_cur) : 4'd0;
    assign o_running_valid  = r_cur_v;
    assign o_switch_request = r_o_sw;
    assign o_lock_level     = r_lock;
    assign o_woken_count    = r_o_wk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_order  <= '0;
            r_fhead  <= '0;
            r_fcount <= CW'(TASKS);
            r_cur_v  <= 1'b0;
            r_cur    <= '0;
            r_lock   <= '0;
            for (int i = 0; i < TASKS; i++) begin
                r_tst[i]   <= ST_DEAD;
                r_prio[i]  <= '0;
                r_tag[i]   <= '0;
                r_stamp[i] <= '0;
                r_fifo[i]  <= TW'(i);
            end
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !r_ovalid) begin
                        r_cmd   <= i_word;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_o_res <= '0;
                    r_o_st  <= STATUS_OK;
                    r_woken <= '0;
                    r_sched <= 1'b0;
                    r_state <= S_DONE;
                    unique case (r_cmd.cmd)
                        CMD_CREATE: begin
                            if (r_fcount == '0) begin
                                r_o_st <= STATUS_FULL;
                            end else begin
                                r_prio[r_fifo[r_fhead]]  <= sat_p;
                                r_tag[r_fifo[r_fhead]]   <= '0;
                                r_tst[r_fifo[r_fhead]]   <= ST_READY;
                                r_stamp[r_fifo[r_fhead]] <= r_order;
                                r_order  <= r_order + 8'd1;
                                r_o_res  <= 4'(r_fifo[r_fhead]);
                                r_fhead  <= (32'(r_fhead) == TASKS - 1) ? '0 : r_fhead + 1'b1;
                                r_fcount <= r_fcount - 1'b1;
                            end
                        end
                        CMD_DELETE: begin
                            if (tbad || r_tst[tix] == ST_DEAD) begin
                                r_o_st <= STATUS_ILLEGAL;
                            end else begin
                                if (r_tst[tix] == ST_READY || r_tst[tix] == ST_BLOCKED) begin
                                    for (int i = 0; i < TASKS; i++)
                                        if (TW'(i) != tix && (r_tst[i] == ST_READY ||
                                            r_tst[i] == ST_BLOCKED) && r_stamp[i] > r_stamp[tix])
                                            r_stamp[i] <= r_stamp[i] - 8'd1;
                                    if (r_order != 0) r_order <= r_order - 8'd1;
                                end
                                if (r_tst[tix] == ST_RUNNING) r_cur_v <= 1'b0;
                                r_stamp[tix] <= '0;
                                r_tst[tix]   <= ST_DEAD;
                                r_tag[tix]   <= '0;
                                if (32'(r_fcount) < TASKS) begin
                                    r_fifo[TW'((CW+1)'(r_fhead) + (CW+1)'(r_fcount)
                                        - (((CW+1)'(r_fhead) + (CW+1)'(r_fcount)
                                        >= (CW+1)'(TASKS)) ? (CW+1)'(TASKS) : '0))] <= tix;
                                    r_fcount <= r_fcount + 1'b1;
                                end
                                r_sched  <= 1'b1;
                                r_wtag   <= 16'h8000 | 16'(tix);
                                r_wlimit <= 8'd255;
                                r_idx    <= '0;
                                r_best_v <= 1'b0;
                                r_state  <= S_WAKE;
                            end
                        end
                        CMD_SETPRIO: begin
                            if (tbad) begin
                                r_o_st <= STATUS_ILLEGAL;
                            end else if (r_tst[tix] == ST_READY) begin
                                for (int i = 0; i < TASKS; i++)
                                    if (TW'(i) != tix && (r_tst[i] == ST_READY ||
                                        r_tst[i] == ST_BLOCKED) && r_stamp[i] > r_stamp[tix])
                                        r_stamp[i] <= r_stamp[i] - 8'd1;
                                r_stamp[tix] <= r_order - 8'd1;
                                r_prio[tix]  <= sat_p;
                                r_sched      <= 1'b1;
                            end else begin
                                r_prio[tix] <= sat_p;
                            end
                        end
                        CMD_WAIT, CMD_JOIN: begin
                            if (!r_cur_v || (r_cmd.cmd == CMD_WAIT && r_cmd.event_tag == '0)
                                || (r_cmd.cmd == CMD_JOIN && tbad)) begin
                                r_o_st <= STATUS_ILLEGAL;
                            end else if (r_cmd.cmd == CMD_WAIT || r_tst[tix] != ST_DEAD) begin
                                r_tst[r_cur]   <= ST_BLOCKED;
                                r_tag[r_cur]   <= (r_cmd.cmd == CMD_WAIT) ?
                                    {1'b0, r_cmd.event_tag} : (16'h8000 | 16'(tix));
                                r_stamp[r_cur] <= r_order;
                                r_order        <= r_order + 8'd1;
                                r_cur_v        <= 1'b0;
                                r_sched        <= 1'b1;
                            end
                        end
                        CMD_WAKEUP: begin
                            if (r_cmd.event_tag == '0) begin
                                r_o_st <= STATUS_ILLEGAL;
                            end else begin
                                r_wtag   <= {1'b0, r_cmd.event_tag};
                                r_wlimit <= r_cmd.wake_limit;
                                r_idx    <= '0;
                                r_best_v <= 1'b0;
                                r_state  <= S_WAKE;
                            end
                        end
                        CMD_SUSPEND, CMD_RESUME: begin
                            if (tbad || r_tst[tix] == ST_DEAD ||
                                (r_cmd.cmd == CMD_SUSPEND && r_tst[tix] == ST_BLOCKED) ||
                                (r_cmd.cmd == CMD_RESUME && r_tst[tix] == ST_READY)) begin
                                r_o_st <= STATUS_ILLEGAL;
                            end else begin
                                if (r_tst[tix] == ST_RUNNING) begin
                                    r_cur_v      <= 1'b0;
                                    r_stamp[tix] <= r_order;
                                    r_order      <= r_order + 8'd1;
                                end else begin
                                    // requeue at tail: remove then append
                                    for (int i = 0; i < TASKS; i++)
                                        if (TW'(i) != tix && (r_tst[i] == ST_READY ||
                                            r_tst[i] == ST_BLOCKED) &&
                                            r_stamp[i] > r_stamp[tix])
                                            r_stamp[i] <= r_stamp[i] - 8'd1;
                                    r_stamp[tix] <= r_order - 8'd1;
                                end
                                if (r_cmd.cmd == CMD_RESUME && r_tst[tix] == ST_BLOCKED)
                                    r_woken <= 5'd1;
                                r_tst[tix] <= (r_cmd.cmd == CMD_SUSPEND) ? ST_BLOCKED : ST_READY;
                                r_tag[tix] <= '0;
                                r_sched    <= 1'b1;
                            end
                        end
                        CMD_SWITCH: begin
                            r_idx    <= '0;
                            r_best_v <= 1'b0;
                            r_state  <= S_SCAN;
                        end
                        CMD_LOCK: begin
                            if (r_lock != 8'd255) r_lock <= r_lock + 8'd1;
                        end
                        CMD_UNLOCK: begin
                            if (r_lock == '0) begin
                                r_o_st <= STATUS_ILLEGAL;
                            end else begin
                                r_lock  <= r_lock - 8'd1;
                                r_sched <= (r_lock == 8'd1);
                            end
                        end
                        CMD_TICK: r_sched <= 1'b1;
                        default: r_o_st <= STATUS_ILLEGAL;
                    endcase
                end
                S_SCAN: begin
                    // one slot per cycle: highest prio, oldest stamp
                    if (32'(r_idx) < TASKS) begin
                        if (r_tst[sidx] == ST_READY && (!r_best_v || r_prio[sidx] > r_bprio ||
                            (r_prio[sidx] == r_bprio && r_stamp[sidx] < r_bstamp))) begin
                            r_best_v <= 1'b1;
                            r_best   <= sidx;
                            r_bprio  <= r_prio[sidx];
                            r_bstamp <= r_stamp[sidx];
                        end
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_state <= S_DONE;
                        if (!r_best_v) begin
                            r_o_res <= r_cur_v ? 4'(r_cur) : 4'd0;
                        end else if (r_cur_v && r_prio[r_cur] > r_bprio) begin
                            r_o_res <= 4'(r_cur);
                        end else begin
                            for (int i = 0; i < TASKS; i++)
                                if (TW'(i) != r_best && (r_tst[i] == ST_READY ||
                                    r_tst[i] == ST_BLOCKED) && r_stamp[i] > r_bstamp)
                                    r_stamp[i] <= r_stamp[i] - 8'd1;
                            r_stamp[r_best] <= '0;
                            r_tst[r_best]   <= ST_RUNNING;
                            if (r_cur_v) begin
                                r_tst[r_cur]   <= ST_READY;
                                r_stamp[r_cur] <= r_order - 8'd1;
                            end else begin
                                r_order <= r_order - 8'd1;
                            end
                            r_cur   <= r_best;
                            r_cur_v <= 1'b1;
                            r_o_res <= 4'(r_best);
                        end
                    end
                end
                S_WAKE: begin
                    if (r_wlimit != 8'd255 && {3'b0, r_woken} >= r_wlimit) begin
                        r_state <= S_DONE;
                    end else if (32'(r_idx) < TASKS) begin
                        if (r_tst[sidx] == ST_BLOCKED && r_tag[sidx] == r_wtag &&
                            (!r_best_v || r_stamp[sidx] < r_bstamp)) begin
                            r_best_v <= 1'b1;
                            r_best   <= sidx;
                            r_bstamp <= r_stamp[sidx];
                        end
                        r_idx <= r_idx + 1'b1;
                    end else if (!r_best_v) begin
                        r_state <= S_DONE;
                    end else begin
                        // move oldest waiter to ready tail, then rescan
                        for (int i = 0; i < TASKS; i++)
                            if (TW'(i) != r_best && (r_tst[i] == ST_READY ||
                                r_tst[i] == ST_BLOCKED) && r_stamp[i] > r_bstamp)
                                r_stamp[i] <= r_stamp[i] - 8'd1;
                        r_stamp[r_best] <= r_order - 8'd1;
                        r_tst[r_best]   <= ST_READY;
                        r_tag[r_best]   <= '0;
                        if (r_woken != 5'd31) r_woken <= r_woken + 5'd1;
                        if (r_cmd.cmd == CMD_WAKEUP) r_sched <= 1'b1;
                        r_idx    <= '0;
                        r_best_v <= 1'b0;
                    end
                end
                S_DONE: begin
                    r_o_wk   <= r_woken;
                    r_o_sw   <= r_sched && (r_lock == '0);
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_cur_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE && r_cur_v |-> r_tst[r_cur] == ST_RUNNING)
        else $error("current task not running");
    a_fcount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fcount) <= TASKS) else $error("free count overflow");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_state == S_IDLE) else $error("engine busy with result pending");
endmodule

// File: design/priority_bitmap_task_scheduler.sv
// Priority bitmap task scheduler.
// Input channel: i_valid / o_ready carry one command word (cmd, target task,
// priority, event tag, wake limit). Output channel: o_valid / i_ready carry
// one result word per command: result task, status, running task, lock level,
// switch request and woken count.
// A two-entry command queue sits in front of the execution engine, so the
// sender can post the next word while the engine is busy.
// After the queue takes a command, the engine captures it in S_IDLE, executes
// it in S_EXEC and raises o_valid from S_DONE. Switch scans the task table one slot per cycle.
// Wakeup and delete rescan the table once per task woken; a wakeup that hits
// its limit stops early.
// One command at a time: the engine takes the next word in the cycle after
// the result word is accepted.
// Reset (synchronous, active low) kills all tasks, fills the free slot list
// with slots in order, clears the lock depth and the current task.
// When the receiver stalls, the result word holds and the engine takes no
// further command; the queue absorbs up to two more words.
module priority_bitmap_task_scheduler #(
    parameter int TASKS       = pbts_pkg::TASKS_DEF,
    parameter int PRIO_LEVELS = pbts_pkg::PRIO_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_cmd,
    input  logic [3:0]  i_target_task,
    input  logic [5:0]  i_priority_req,
    input  logic [14:0] i_event_tag,
    input  logic [7:0]  i_wake_limit,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_result_task,
    output logic [1:0]  o_status,
    output logic [3:0]  o_running_task,
    output logic        o_running_valid,
    output logic        o_switch_request,
    output logic [7:0]  o_lock_level,
    output logic [4:0]  o_woken_count
);
    import pbts_pkg::*;

    t_cmd_word in_word, q_word;
    logic      q_valid, q_ready;

    // pack the command word
    assign in_word = '{cmd: i_cmd, target_task: i_target_task,
                       priority_req: i_priority_req, event_tag: i_event_tag,
                       wake_limit: i_wake_limit};

    pbts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (in_word),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_word  (q_word)
    );

    pbts_engine #(.TASKS(TASKS), .PRIO_LEVELS(PRIO_LEVELS)) u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (q_valid),
        .o_ready          (q_ready),
        .i_word           (q_word),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_task    (o_result_task),
        .o_status         (o_status),
        .o_running_task   (o_running_task),
        .o_running_valid  (o_running_valid),
        .o_switch_request (o_switch_request),
        .o_lock_level     (o_lock_level),
        .o_woken_count    (o_woken_count)
    );
endmodule
